/* hw/rtl/point_to_panorama_pixel_core_macros.svh */
// assertion macros for the panorama pixel core
// used by modules that check their own pipeline behavior
`ifndef POINT_TO_PANORAMA_PIXEL_CORE_MACROS_SVH
`define POINT_TO_PANORAMA_PIXEL_CORE_MACROS_SVH

// same-cycle implication
`define PPP_CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPP_CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ppp_pkg.sv */
// shared constants, types and the arctangent table for the panorama pixel core
// no dependencies
`timescale 1ns / 1ps

package ppp_pkg;

  localparam int PANO_WIDTH_DEF  = 6720;
  localparam int PANO_HEIGHT_DEF = 3360;

  localparam int COORD_W = 32;
  localparam int COL_W   = 13;
  localparam int ROW_W   = 12;
  localparam int THR_W   = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd19661;

  // squared magnitudes and integer square root
  localparam int SQ_W        = 64;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = ROOT_W;

  // binary angles: 2^32 is one turn
  localparam int ANG_W = 32;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 36;

  // cos(elevation) in q1.18
  localparam int C_FRAC = 18;
  localparam int C_W    = C_FRAC + 1;

  localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef logic signed [CORDIC_W-1:0] cordic_word_t;

endpackage

/* hw/rtl/ppp_delay.sv */
// fixed-length shift line with a shared advance enable
// depends on nothing
`timescale 1ns / 1ps

module ppp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= din;
      for (int i = 1; i < N; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[N-1];

endmodule

/* hw/rtl/ppp_isqrt.sv */
// pipelined integer square root, one root bit per stage
// depends on ppp_pkg
`timescale 1ns / 1ps

module ppp_isqrt import ppp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   din,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem [SQRT_STEPS];
  logic [ROOT_W-1:0] rt  [SQRT_STEPS];
  logic [SQ_W-1:0]   val [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    logic [REM_W-1:0]  rem_in, r2, trial;
    logic [ROOT_W-1:0] rt_in;
    logic [SQ_W-1:0]   val_in;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign val_in = din;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign rt_in  = rt[s-1];
      assign val_in = val[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign r2    = {rem_in[REM_W-3:0], val_in[SQ_W-1 -: 2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? (r2 - trial) : r2;
        rt[s]  <= {rt_in[ROOT_W-2:0], ge};
        val[s] <= {val_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_STEPS-1];

endmodule

/* hw/rtl/ppp_cordic.sv */
// pipelined vectoring cordic, one micro-rotation per stage, returns the angle
// depends on ppp_pkg
`timescale 1ns / 1ps

module ppp_cordic import ppp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  cordic_word_t     x_in,
  input  cordic_word_t     y_in,
  input  logic [ANG_W-1:0] z_in,
  output logic [ANG_W-1:0] z_out
);

  cordic_word_t     xs [CORDIC_STEPS];
  cordic_word_t     ys [CORDIC_STEPS];
  logic [ANG_W-1:0] zs [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cordic_word_t     xi, yi;
    logic [ANG_W-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
    end

    // rotate toward the x axis, arithmetic shifts floor
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[CORDIC_W-1]) begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + ATAN_TAB[i];
        end else begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - ATAN_TAB[i];
        end
      end
    end
  end

  assign z_out = zs[CORDIC_STEPS-1];

endmodule

/* hw/rtl/ppp_div.sv */
// pipelined restoring divider for cos(elevation) = floor(rho * 2^18 / r)
// depends on ppp_pkg
`timescale 1ns / 1ps

module ppp_div import ppp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] rho,
  input  logic [ROOT_W-1:0] r,
  output logic [C_W-1:0]    quo
);

  localparam int NUM_W = ROOT_W + C_FRAC;

  logic [NUM_W-1:0]  rem [C_W];
  logic [ROOT_W-1:0] den [C_W];
  logic [C_W-1:0]    q   [C_W];

  for (genvar s = 0; s < C_W; s++) begin : g_step
    logic [NUM_W-1:0]  rem_in, dsh;
    logic [ROOT_W-1:0] den_in;
    logic [C_W-1:0]    q_in;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = {rho, {C_FRAC{1'b0}}};
      assign den_in = r;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign den_in = den[s-1];
      assign q_in   = q[s-1];
    end

    // quotient bit C_FRAC-s: compare against r shifted into place
    assign dsh = {{C_FRAC{1'b0}}, den_in} << (C_FRAC - s);
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? (rem_in - dsh) : rem_in;
        den[s] <= den_in;
        q[s]   <= {q_in[C_W-2:0], ge};
      end
    end
  end

  assign quo = q[C_W-1];

endmodule

/* hw/rtl/point_to_panorama_pixel_core.sv */
// top level: projects a 3d point onto an equirectangular panorama pixel
// depends on ppp_pkg, ppp_delay, ppp_isqrt, ppp_cordic, ppp_div and the macros header
`timescale 1ns / 1ps
//
//  channel   | dir | contents
//  ----------+-----+----------------------------------------------------------
//  s_axis    | in  | tdata: point_x [31:0], point_y [63:32], point_z [95:64]
//  m_axis    | out | tdata: pixel_col [12:0], pixel_row [24:13]; tuser: too_near
//  cfg       | in  | near_threshold, 31 bits, written when cfg_wr_en is high
//
//  one item per cycle while the output is not stalled
//  the path is 3 square/sum stages, a 32-stage square root, a 24-stage cordic
//  for elevation, and 5 multiply, round and clamp stages
//  reset clears all valid bits and sets near_threshold to 0.3 m
//  a stall at the output holds the whole pipeline; nothing is lost or repeated

`include "point_to_panorama_pixel_core_macros.svh"

module point_to_panorama_pixel_core import ppp_pkg::*; #(
  parameter int PANO_WIDTH  = PANO_WIDTH_DEF,
  parameter int PANO_HEIGHT = PANO_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [95:0]      s_tdata,   // point_x, point_y, point_z
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // pixel_col, pixel_row, zero fill
  output logic [0:0]       m_tuser,   // too_near
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  localparam int WB    = $clog2(PANO_WIDTH + 1);
  localparam int HB    = $clog2(PANO_HEIGHT + 1);
  localparam int CWW   = C_W + WB;
  localparam int OFF_W = WB + 2;
  localparam int SUM_W = ((WB > HB) ? WB : HB) + 3;
  localparam int PLO_W = 17;

  localparam logic [WB-1:0]           W_C      = WB'(PANO_WIDTH);
  localparam logic signed [SUM_W-1:0] HALF_W   = SUM_W'(PANO_WIDTH / 2);
  localparam logic signed [SUM_W-1:0] HALF_H   = SUM_W'(PANO_HEIGHT / 2);
  localparam logic signed [SUM_W-1:0] W_MAX    = SUM_W'(PANO_WIDTH - 1);
  localparam logic signed [SUM_W-1:0] H_MAX    = SUM_W'(PANO_HEIGHT - 1);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // threshold register and its square
  logic [THR_W-1:0]   thr;
  logic [2*THR_W-1:0] thr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    thr_sq <= {{THR_W{1'b0}}, thr} * {{THR_W{1'b0}}, thr};
  end

  // stage 1: squares and azimuth pre-rotation; later stages sum the squares and test the near threshold
  logic signed [COORD_W-1:0] sx, sy, sz;
  assign sx = $signed(s_tdata[31:0]);
  assign sy = $signed(s_tdata[63:32]);
  assign sz = $signed(s_tdata[95:64]);

  logic                v1, v2, v3, v4, near4;
  logic [SQ_W-1:0]     xx1, yy1, zz1, zz2, hsq2, hsq3, sum3;
  logic [COORD_W-1:0]  z1;
  cordic_word_t        ax1, ay1;
  logic [ANG_W-1:0]    az01;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx1 <= SQ_W'(SQ_W'(sx) * SQ_W'(sx));
      yy1 <= SQ_W'(SQ_W'(sy) * SQ_W'(sy));
      zz1 <= SQ_W'(SQ_W'(sz) * SQ_W'(sz));
      z1  <= sz;
      // left half plane: turn by half a turn first
      if (sx < 0) begin
        ax1  <= -CORDIC_W'(sx);
        ay1  <= -CORDIC_W'(sy);
        az01 <= HALF_TURN;
      end else begin
        ax1  <= CORDIC_W'(sx);
        ay1  <= CORDIC_W'(sy);
        az01 <= '0;
      end
      hsq2  <= xx1 + yy1;
      zz2   <= zz1;
      hsq3  <= hsq2;
      sum3  <= hsq2 + zz2;
      near4 <= (sum3 == '0) || (sum3 < thr_sq);
    end
  end

  // ranges
  logic [ROOT_W-1:0] rho35, r35;

  ppp_isqrt u_sqrt_rho (.clk(clk), .en(en), .din(hsq3), .root(rho35));
  ppp_isqrt u_sqrt_r   (.clk(clk), .en(en), .din(sum3), .root(r35));

  // azimuth
  logic [ANG_W-1:0] az25, az59;

  ppp_cordic u_cordic_az (
    .clk(clk), .en(en), .x_in(ax1), .y_in(ay1), .z_in(az01), .z_out(az25)
  );

  ppp_delay #(.W(ANG_W), .N(34)) u_dly_az (
    .clk(clk), .rst(rst), .en(en), .din(az25), .dout(az59)
  );

  // elevation
  logic [COORD_W-1:0] z35;
  cordic_word_t       ex35, ey35;
  logic [ANG_W-1:0]   el59;

  ppp_delay #(.W(COORD_W), .N(34)) u_dly_z (
    .clk(clk), .rst(rst), .en(en), .din(z1), .dout(z35)
  );

  assign ex35 = $signed(CORDIC_W'(rho35));
  assign ey35 = -CORDIC_W'($signed(z35));

  ppp_cordic u_cordic_el (
    .clk(clk), .en(en), .x_in(ex35), .y_in(ey35), .z_in('0), .z_out(el59)
  );

  // cos(elevation)
  logic [C_W-1:0] c54, c59;

  ppp_div u_div (.clk(clk), .en(en), .rho(rho35), .r(r35), .quo(c54));

  ppp_delay #(.W(C_W), .N(5)) u_dly_c (
    .clk(clk), .rst(rst), .en(en), .din(c54), .dout(c59)
  );

  // valid and near flag ride along to stage 63
  logic v63, near63;

  ppp_delay #(.W(2), .N(59)) u_dly_flag (
    .clk(clk), .rst(rst), .en(en), .din({v4, near4}), .dout({v63, near63})
  );

  // stages 60 to 63: scaling, floor, offsets
  logic [ANG_W-1:0]       theta59;
  logic [ANG_W-1:0]       abs_t60, abs_p60;
  logic                   neg_t60, neg_p60, neg_t61, neg_p61, neg_t62, neg_p62;
  logic [CWW-1:0]         cw60;
  logic [ANG_W+PLO_W-1:0] plo61;
  logic [ANG_W+CWW-PLO_W-1:0] phi61;
  logic [ANG_W+WB-1:0]    rmag61, rmag62;
  logic [SQ_W-1:0]        cmag62;
  logic [OFF_W-1:0]       cq, rq;
  logic                   cfrac, rfrac;
  logic signed [OFF_W-1:0] coff63, roff63;

  assign theta59 = -az59;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_t60 <= theta59[ANG_W-1];
      abs_t60 <= theta59[ANG_W-1] ? -theta59 : theta59;
      neg_p60 <= el59[ANG_W-1];
      abs_p60 <= el59[ANG_W-1] ? -el59 : el59;
      cw60    <= CWW'(c59) * CWW'(W_C);

      neg_t61 <= neg_t60;
      neg_p61 <= neg_p60;
      plo61   <= (ANG_W+PLO_W)'(abs_t60) * (ANG_W+PLO_W)'(cw60[PLO_W-1:0]);
      phi61   <= (ANG_W+CWW-PLO_W)'(abs_t60) * (ANG_W+CWW-PLO_W)'(cw60[CWW-1:PLO_W]);
      rmag61  <= (ANG_W+WB)'(abs_p60) * (ANG_W+WB)'(W_C);

      neg_t62 <= neg_t61;
      neg_p62 <= neg_p61;
      cmag62  <= SQ_W'(plo61) + (SQ_W'(phi61) << PLO_W);
      rmag62  <= rmag61;

      // floor of a signed value: round the magnitude up when negative
      coff63  <= neg_t62 ? -$signed(cq + OFF_W'(cfrac)) : $signed(cq);
      roff63  <= neg_p62 ? -$signed(rq + OFF_W'(rfrac)) : $signed(rq);
    end
  end

  assign cq    = OFF_W'(cmag62 >> 50);
  assign cfrac = |cmag62[49:0];
  assign rq    = OFF_W'(rmag62 >> ANG_W);
  assign rfrac = |rmag62[ANG_W-1:0];

  // stage 64: center, clamp, output register
  logic signed [SUM_W-1:0] col_s, row_s, col_c, row_c;

  assign col_s = SUM_W'(coff63) + HALF_W;
  assign row_s = SUM_W'(roff63) + HALF_H;

  always_comb begin
    if (col_s < 0)          col_c = '0;
    else if (col_s > W_MAX) col_c = W_MAX;
    else                    col_c = col_s;
    if (row_s < 0)          row_c = '0;
    else if (row_s > H_MAX) row_c = H_MAX;
    else                    row_c = row_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v63;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[0] <= near63;
      if (near63) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {7'b0, row_c[ROW_W-1:0], col_c[COL_W-1:0]};
      end
    end
  end

  `PPP_CHK_IMPL(a_near_pixel_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0, "too-near item carries a pixel")
  `PPP_CHK_IMPL(a_col_in_image, clk, rst, m_tvalid && (PANO_WIDTH <= 8192), 32'(m_tdata[COL_W-1:0]) <= PANO_WIDTH - 1, "column outside the image")
  `PPP_CHK_IMPL(a_row_in_image, clk, rst, m_tvalid && (PANO_HEIGHT <= 4096), 32'(m_tdata[COL_W+ROW_W-1:COL_W]) <= PANO_HEIGHT - 1, "row outside the image")
  `PPP_CHK_NEXT(a_pipe_drains, clk, rst, en && v63, m_tvalid, "finished item did not reach the output")

endmodule
